### src/gn2d_pkg.sv
// gn2d_pkg: widths, constants and shared types of the gradient noise block
// no dependencies; used by gradient_noise_2d by scoped names
package gn2d_pkg;

    localparam int POS_W    = 20;   // unsigned 12.8 position
    localparam int RECIP_W  = 17;   // unsigned Q1.16 reciprocal cell size
    localparam int PROD_W   = POS_W + RECIP_W;
    localparam int PINT_W   = PROD_W - 24;  // integer part of the scaled position
    localparam int FRAC_W   = 16;
    localparam int TAB_AW   = 9;
    localparam int TAB_DEPTH = 512;
    localparam int BYTE_W   = 8;
    localparam int FADE_W   = 17;   // 0..65536
    localparam int DOT_W    = 33;   // dot product terms before rounding
    localparam int DQ_W     = 18;   // dot product in Q.16
    localparam int NOISE_W  = 16;

    localparam logic [RECIP_W-1:0] CELL_RECIP_RESET = 17'd6554;
    localparam logic [14:0]        GRAD_UNIT        = 15'd11585;

    // offsets that turn f terms into (f - 1) terms
    localparam logic signed [DOT_W-1:0] UNIT_OFF = 33'sd759234560;
    localparam logic signed [DOT_W-1:0] ONE_OFF  = 33'sd1073741824;
    localparam logic signed [DOT_W-1:0] DOT_HALF = 33'sd8192;

    localparam logic signed [17:0] NOISE_MAX = 18'sd16384;
    localparam logic signed [17:0] NOISE_MIN = -18'sd16384;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // gradient picked by the low three bits of the hashed table byte
    typedef enum logic [2:0] {
        GRAD_PP = 3'd0,
        GRAD_NP = 3'd1,
        GRAD_PN = 3'd2,
        GRAD_NN = 3'd3,
        GRAD_XP = 3'd4,
        GRAD_XN = 3'd5,
        GRAD_YP = 3'd6,
        GRAD_YN = 3'd7
    } grad_sel_t;

    // corner offset products: u* scaled by 1/sqrt(2), o* scaled by one
    typedef struct packed {
        logic signed [DOT_W-1:0] ux0;
        logic signed [DOT_W-1:0] ux1;
        logic signed [DOT_W-1:0] uy0;
        logic signed [DOT_W-1:0] uy1;
        logic signed [DOT_W-1:0] ox0;
        logic signed [DOT_W-1:0] ox1;
        logic signed [DOT_W-1:0] oy0;
        logic signed [DOT_W-1:0] oy1;
    } terms_t;

endpackage

### src/gradient_noise_2d.sv
// gradient_noise_2d: pipelined 2d gradient noise with a loadable permutation table
// depends on gn2d_pkg
//
// Usage:
//   Input channel s_*: each transfer is a load item (s_req_type 0) that writes
//   s_table_value into table entry s_table_index, or an evaluate item
//   (s_req_type 1) that samples noise at (s_x_pos, s_y_pos), 12.8 fixed point.
//   Result channel m_*: one signed Q1.14 m_noise_value per evaluate item, in
//   order; load items give no result. Every table entry that an evaluate item
//   hashes to must have been loaded by an earlier item.
//   Config channel cfg_*: cfg_cell_recip sets the reciprocal cell size (Q1.16),
//   always ready; write it only while no item is in flight.
//   Throughput: one item per cycle while m_ready is high. The input transfer
//   reaches m_valid through 13 register stages (two scale multiplies, the
//   constant-divide wrap, the fade polynomial, two table reads, dot products
//   and three lerp multiplies).
//   The table is held in three copies, each read at two addresses a cycle.
//   Reset: clears the pipeline valids and sets cell_recip to 6554; the table
//   keeps its contents and is undefined until loaded.
//   Stall: when m_ready is low the result holds; earlier stages keep filling
//   empty slots, and s_ready drops only when every stage holds an item.
module gradient_noise_2d #(
    parameter int LATTICE_SIZE = 256
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gn2d_pkg::RECIP_W-1:0]            cfg_cell_recip,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_req_type,
    input  logic [gn2d_pkg::TAB_AW-1:0]             s_table_index,
    input  logic [gn2d_pkg::BYTE_W-1:0]             s_table_value,
    input  logic [gn2d_pkg::POS_W-1:0]              s_x_pos,
    input  logic [gn2d_pkg::POS_W-1:0]              s_y_pos,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [gn2d_pkg::NOISE_W-1:0]     m_noise_value
);

    localparam int NST     = 13;
    localparam int PINT_W  = gn2d_pkg::PINT_W;
    localparam int PROD_W  = gn2d_pkg::PROD_W;
    localparam int TAB_AW  = gn2d_pkg::TAB_AW;
    localparam int DOT_W   = gn2d_pkg::DOT_W;
    localparam int DQ_W    = gn2d_pkg::DQ_W;
    localparam int FADE_W  = gn2d_pkg::FADE_W;
    localparam int FRAC_W  = gn2d_pkg::FRAC_W;
    localparam int BYTE_W  = gn2d_pkg::BYTE_W;
    localparam int LAT_W   = $clog2(LATTICE_SIZE);
    localparam int REM_W   = LAT_W + 1;
    // wrap to the lattice: q = (p * MOD_RECIP) >> MOD_SH is q or q - 1
    localparam int MOD_SH    = 21;
    localparam int MOD_RECIP = (1 << MOD_SH) / LATTICE_SIZE;
    localparam int MREC_W    = $clog2(MOD_RECIP + 1);
    localparam int QPROD_W   = PINT_W + MREC_W;
    localparam logic [REM_W-1:0]  LAT_K  = REM_W'(LATTICE_SIZE);
    localparam logic [PINT_W-1:0] LAT_KP = PINT_W'(LATTICE_SIZE);

    // ---------------------------------------------------------------------
    // config register and pipeline control
    // ---------------------------------------------------------------------
    logic [gn2d_pkg::RECIP_W-1:0] recip_reg;
    logic [NST:1]                 vld_reg;
    logic [NST-1:1]               evl_reg;
    logic [NST:1]                 en;

    assign cfg_ready = 1'b1;
    assign s_ready   = en[1];
    assign m_valid   = vld_reg[NST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_reg <= gn2d_pkg::CELL_RECIP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            recip_reg <= cfg_cell_recip;
        end
    end

    // a stage loads when it is empty or the stage after it loads
    always_comb begin
        en[NST] = !vld_reg[NST] || m_ready;
        for (int k = NST - 1; k >= 1; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[1]) begin
                vld_reg[1] <= s_valid;
            end
            for (int k = 2; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            // load items end here
            if (en[NST]) begin
                vld_reg[NST] <= vld_reg[NST-1] && evl_reg[NST-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            evl_reg[1] <= (s_req_type == gn2d_pkg::REQ_EVAL);
        end
        for (int k = 2; k < NST; k++) begin
            if (en[k]) begin
                evl_reg[k] <= evl_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // stage registers
    // ---------------------------------------------------------------------
    logic [TAB_AW-1:0]        s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg, s5_idx_reg;
    logic [TAB_AW-1:0]        s6_idx_reg;
    logic [BYTE_W-1:0]        s1_val_reg, s2_val_reg, s3_val_reg, s4_val_reg, s5_val_reg;
    logic [BYTE_W-1:0]        s6_val_reg;
    logic [gn2d_pkg::POS_W-1:0] s1_x_reg, s1_y_reg;

    logic [PROD_W-1:0]        s2_px_reg, s2_py_reg;

    logic [QPROD_W-1:0]       s3_qpx_reg, s3_qpy_reg;
    logic [PINT_W-1:0]        s3_pix_reg, s3_piy_reg;
    logic [FRAC_W-1:0]        s3_fx_reg, s3_fy_reg;
    logic [31:0]              s3_t2x_reg, s3_t2y_reg;
    logic [29:0]              s3_umx_reg, s3_umy_reg;

    logic [PINT_W-1:0]        s4_qlx_reg, s4_qly_reg, s4_pix_reg, s4_piy_reg;
    logic [FRAC_W-1:0]        s4_fx_reg, s4_fy_reg;
    logic [31:0]              s4_t2x_reg, s4_t2y_reg;
    logic [47:0]              s4_t3x_reg, s4_t3y_reg;
    logic [29:0]              s4_umx_reg, s4_umy_reg;

    logic [LAT_W-1:0]         s5_ii_reg, s5_jj_reg, s6_ii_reg;
    logic [FADE_W-1:0]        s5_cx_reg, s5_cy_reg, s6_cx_reg, s6_cy_reg;
    logic [FADE_W-1:0]        s7_cx_reg, s7_cy_reg, s8_cx_reg, s8_cy_reg;
    logic [FADE_W-1:0]        s9_cy_reg, s10_cy_reg;
    gn2d_pkg::terms_t         s5_tm_reg, s6_tm_reg, s7_tm_reg;

    logic [BYTE_W-1:0]        s6_pj0_reg, s6_pj1_reg;
    logic [2:0]               s7_g_reg [4];
    logic signed [DQ_W-1:0]   s8_dq_reg [4];

    logic signed [36:0]       s9_pa_reg, s9_pb_reg;
    logic signed [DQ_W-1:0]   s9_s_reg, s9_u_reg;
    logic signed [18:0]       s10_l1_reg, s10_l2_reg, s11_l1_reg;
    logic signed [37:0]       s11_pl_reg;
    logic signed [19:0]       s12_lv_reg;
    logic signed [gn2d_pkg::NOISE_W-1:0] noise_reg;

    logic [BYTE_W-1:0]        perm_a_mem [gn2d_pkg::TAB_DEPTH];
    logic [BYTE_W-1:0]        perm_b_mem [gn2d_pkg::TAB_DEPTH];
    logic [BYTE_W-1:0]        perm_c_mem [gn2d_pkg::TAB_DEPTH];

    assign m_noise_value = noise_reg;

    // ---------------------------------------------------------------------
    // next values
    // ---------------------------------------------------------------------
    logic [QPROD_W-1:0]       qpx_next, qpy_next;
    logic [PINT_W-1:0]        qlx_next, qly_next, remx_full, remy_full;
    logic [REM_W-1:0]         remx, remy;
    logic [LAT_W-1:0]         ii_next, jj_next;
    logic [50:0]              cpx, cpy, cpx_rnd, cpy_rnd;
    logic [FADE_W-1:0]        cx_next, cy_next;
    gn2d_pkg::terms_t         tm_next;
    logic [TAB_AW-1:0]        a0_addr, a1_addr, b0_addr, b1_addr, c0_addr, c1_addr, ii_ext;
    logic signed [DQ_W-1:0]   dq_next [4];
    logic signed [DQ_W:0]     dts, dvu;
    logic signed [36:0]       pa_next, pb_next, pa_rnd, pb_rnd;
    logic signed [20:0]       l1_sum, l2_sum;
    logic signed [19:0]       dl;
    logic signed [37:0]       pl_next, pl_rnd;
    logic signed [21:0]       lv_sum;
    logic signed [19:0]       lv_rnd;
    logic signed [17:0]       r_q;
    logic signed [gn2d_pkg::NOISE_W-1:0] noise_next;
    logic                     wr_a, wr_bc;

    // stage 3: lattice quotient estimate, fade square, 1/sqrt(2) products
    assign qpx_next = QPROD_W'(s2_px_reg[PROD_W-1:24]) * QPROD_W'(MOD_RECIP);
    assign qpy_next = QPROD_W'(s2_py_reg[PROD_W-1:24]) * QPROD_W'(MOD_RECIP);

    // stage 4: quotient times lattice size
    assign qlx_next = PINT_W'(s3_qpx_reg[QPROD_W-1:MOD_SH]) * LAT_KP;
    assign qly_next = PINT_W'(s3_qpy_reg[QPROD_W-1:MOD_SH]) * LAT_KP;

    // stage 5: remainder below twice the lattice size, one correction
    assign remx_full = s4_pix_reg - s4_qlx_reg;
    assign remy_full = s4_piy_reg - s4_qly_reg;
    assign remx      = remx_full[REM_W-1:0];
    assign remy      = remy_full[REM_W-1:0];
    assign ii_next   = (remx >= LAT_K) ? LAT_W'(remx - LAT_K) : LAT_W'(remx);
    assign jj_next   = (remy >= LAT_K) ? LAT_W'(remy - LAT_K) : LAT_W'(remy);

    // fade 3t^2 - 2t^3 in Q.48, rounded to Q1.16
    assign cpx     = {3'b0, s4_t2x_reg, 16'b0} + {2'b0, s4_t2x_reg, 17'b0}
                   - {2'b0, s4_t3x_reg, 1'b0};
    assign cpy     = {3'b0, s4_t2y_reg, 16'b0} + {2'b0, s4_t2y_reg, 17'b0}
                   - {2'b0, s4_t3y_reg, 1'b0};
    assign cpx_rnd = cpx + {19'b0, 1'b1, 31'b0};
    assign cpy_rnd = cpy + {19'b0, 1'b1, 31'b0};
    assign cx_next = cpx_rnd[48:32];
    assign cy_next = cpy_rnd[48:32];

    always_comb begin
        tm_next.ux0 = $signed({3'b0, s4_umx_reg});
        tm_next.uy0 = $signed({3'b0, s4_umy_reg});
        tm_next.ux1 = $signed({3'b0, s4_umx_reg}) - gn2d_pkg::UNIT_OFF;
        tm_next.uy1 = $signed({3'b0, s4_umy_reg}) - gn2d_pkg::UNIT_OFF;
        tm_next.ox0 = $signed({3'b0, s4_fx_reg, 14'b0});
        tm_next.oy0 = $signed({3'b0, s4_fy_reg, 14'b0});
        tm_next.ox1 = $signed({3'b0, s4_fx_reg, 14'b0}) - gn2d_pkg::ONE_OFF;
        tm_next.oy1 = $signed({3'b0, s4_fy_reg, 14'b0}) - gn2d_pkg::ONE_OFF;
    end

    // table addresses: row hash from copy a, corner hashes from copies b and c
    assign a0_addr = TAB_AW'(s5_jj_reg);
    assign a1_addr = a0_addr + TAB_AW'(1);
    assign ii_ext  = TAB_AW'(s6_ii_reg);
    assign b0_addr = ii_ext + TAB_AW'(s6_pj0_reg);
    assign b1_addr = b0_addr + TAB_AW'(1);
    assign c0_addr = ii_ext + TAB_AW'(s6_pj1_reg);
    assign c1_addr = c0_addr + TAB_AW'(1);

    // each copy sees loads and reads in item order at its own stage
    assign wr_a  = en[6] && vld_reg[5] && !evl_reg[5];
    assign wr_bc = en[7] && vld_reg[6] && !evl_reg[6];

    function automatic logic signed [DQ_W-1:0] grad_dot(
        input logic [2:0]              g,
        input logic signed [DOT_W-1:0] ux,
        input logic signed [DOT_W-1:0] uy,
        input logic signed [DOT_W-1:0] ox,
        input logic signed [DOT_W-1:0] oy
    );
        logic signed [DOT_W-1:0] sum;
        logic signed [DOT_W-1:0] rnd;
        unique case (gn2d_pkg::grad_sel_t'(g))
            gn2d_pkg::GRAD_PP: sum = ux + uy;
            gn2d_pkg::GRAD_NP: sum = uy - ux;
            gn2d_pkg::GRAD_PN: sum = ux - uy;
            gn2d_pkg::GRAD_NN: sum = -ux - uy;
            gn2d_pkg::GRAD_XP: sum = ox;
            gn2d_pkg::GRAD_XN: sum = -ox;
            gn2d_pkg::GRAD_YP: sum = oy;
            gn2d_pkg::GRAD_YN: sum = -oy;
        endcase
        rnd = sum + gn2d_pkg::DOT_HALF;
        return rnd[DQ_W+13:14];
    endfunction

    // stage 8: four corner dot products
    assign dq_next[0] = grad_dot(s7_g_reg[0], s7_tm_reg.ux0, s7_tm_reg.uy0,
                                 s7_tm_reg.ox0, s7_tm_reg.oy0);
    assign dq_next[1] = grad_dot(s7_g_reg[1], s7_tm_reg.ux1, s7_tm_reg.uy0,
                                 s7_tm_reg.ox1, s7_tm_reg.oy0);
    assign dq_next[2] = grad_dot(s7_g_reg[2], s7_tm_reg.ux0, s7_tm_reg.uy1,
                                 s7_tm_reg.ox0, s7_tm_reg.oy1);
    assign dq_next[3] = grad_dot(s7_g_reg[3], s7_tm_reg.ux1, s7_tm_reg.uy1,
                                 s7_tm_reg.ox1, s7_tm_reg.oy1);

    // stage 9/10: lerp along x
    assign dts     = $signed({s8_dq_reg[1][DQ_W-1], s8_dq_reg[1]})
                   - $signed({s8_dq_reg[0][DQ_W-1], s8_dq_reg[0]});
    assign dvu     = $signed({s8_dq_reg[3][DQ_W-1], s8_dq_reg[3]})
                   - $signed({s8_dq_reg[2][DQ_W-1], s8_dq_reg[2]});
    assign pa_next = $signed({1'b0, s8_cx_reg}) * dts;
    assign pb_next = $signed({1'b0, s8_cx_reg}) * dvu;
    assign pa_rnd  = s9_pa_reg + 37'sd32768;
    assign pb_rnd  = s9_pb_reg + 37'sd32768;
    assign l1_sum  = $signed(pa_rnd[36:16]) + $signed({{3{s9_s_reg[DQ_W-1]}}, s9_s_reg});
    assign l2_sum  = $signed(pb_rnd[36:16]) + $signed({{3{s9_u_reg[DQ_W-1]}}, s9_u_reg});

    // stage 11/12: lerp along y
    assign dl      = $signed({s10_l2_reg[18], s10_l2_reg})
                   - $signed({s10_l1_reg[18], s10_l1_reg});
    assign pl_next = $signed({1'b0, s10_cy_reg}) * dl;
    assign pl_rnd  = s11_pl_reg + 38'sd32768;
    assign lv_sum  = $signed(pl_rnd[37:16]) + $signed({{3{s11_l1_reg[18]}}, s11_l1_reg});

    // stage 13: Q.16 to Q1.14, rounded half up, saturated
    assign lv_rnd = s12_lv_reg + 20'sd2;
    assign r_q    = lv_rnd[19:2];

    always_comb begin
        priority if (r_q > gn2d_pkg::NOISE_MAX) begin
            noise_next = gn2d_pkg::NOISE_W'(gn2d_pkg::NOISE_MAX);
        end else if (r_q < gn2d_pkg::NOISE_MIN) begin
            noise_next = gn2d_pkg::NOISE_W'(gn2d_pkg::NOISE_MIN);
        end else begin
            noise_next = r_q[gn2d_pkg::NOISE_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_idx_reg <= s_table_index;
            s1_val_reg <= s_table_value;
            s1_x_reg   <= s_x_pos;
            s1_y_reg   <= s_y_pos;
        end
        if (en[2]) begin
            s2_px_reg  <= PROD_W'(s1_x_reg) * PROD_W'(recip_reg);
            s2_py_reg  <= PROD_W'(s1_y_reg) * PROD_W'(recip_reg);
            s2_idx_reg <= s1_idx_reg;
            s2_val_reg <= s1_val_reg;
        end
        if (en[3]) begin
            s3_qpx_reg <= qpx_next;
            s3_qpy_reg <= qpy_next;
            s3_pix_reg <= s2_px_reg[PROD_W-1:24];
            s3_piy_reg <= s2_py_reg[PROD_W-1:24];
            s3_fx_reg  <= s2_px_reg[23:8];
            s3_fy_reg  <= s2_py_reg[23:8];
            s3_t2x_reg <= 32'(s2_px_reg[23:8]) * 32'(s2_px_reg[23:8]);
            s3_t2y_reg <= 32'(s2_py_reg[23:8]) * 32'(s2_py_reg[23:8]);
            s3_umx_reg <= 30'(s2_px_reg[23:8]) * 30'(gn2d_pkg::GRAD_UNIT);
            s3_umy_reg <= 30'(s2_py_reg[23:8]) * 30'(gn2d_pkg::GRAD_UNIT);
            s3_idx_reg <= s2_idx_reg;
            s3_val_reg <= s2_val_reg;
        end
        if (en[4]) begin
            s4_qlx_reg <= qlx_next;
            s4_qly_reg <= qly_next;
            s4_pix_reg <= s3_pix_reg;
            s4_piy_reg <= s3_piy_reg;
            s4_fx_reg  <= s3_fx_reg;
            s4_fy_reg  <= s3_fy_reg;
            s4_t2x_reg <= s3_t2x_reg;
            s4_t2y_reg <= s3_t2y_reg;
            s4_t3x_reg <= 48'(s3_t2x_reg) * 48'(s3_fx_reg);
            s4_t3y_reg <= 48'(s3_t2y_reg) * 48'(s3_fy_reg);
            s4_umx_reg <= s3_umx_reg;
            s4_umy_reg <= s3_umy_reg;
            s4_idx_reg <= s3_idx_reg;
            s4_val_reg <= s3_val_reg;
        end
        if (en[5]) begin
            s5_ii_reg  <= ii_next;
            s5_jj_reg  <= jj_next;
            s5_cx_reg  <= cx_next;
            s5_cy_reg  <= cy_next;
            s5_tm_reg  <= tm_next;
            s5_idx_reg <= s4_idx_reg;
            s5_val_reg <= s4_val_reg;
        end
        if (en[6]) begin
            s6_ii_reg  <= s5_ii_reg;
            s6_cx_reg  <= s5_cx_reg;
            s6_cy_reg  <= s5_cy_reg;
            s6_tm_reg  <= s5_tm_reg;
            s6_idx_reg <= s5_idx_reg;
            s6_val_reg <= s5_val_reg;
        end
        if (en[7]) begin
            s7_cx_reg <= s6_cx_reg;
            s7_cy_reg <= s6_cy_reg;
            s7_tm_reg <= s6_tm_reg;
        end
        if (en[8]) begin
            for (int c = 0; c < 4; c++) begin
                s8_dq_reg[c] <= dq_next[c];
            end
            s8_cx_reg <= s7_cx_reg;
            s8_cy_reg <= s7_cy_reg;
        end
        if (en[9]) begin
            s9_pa_reg <= pa_next;
            s9_pb_reg <= pb_next;
            s9_s_reg  <= s8_dq_reg[0];
            s9_u_reg  <= s8_dq_reg[2];
            s9_cy_reg <= s8_cy_reg;
        end
        if (en[10]) begin
            s10_l1_reg <= l1_sum[18:0];
            s10_l2_reg <= l2_sum[18:0];
            s10_cy_reg <= s9_cy_reg;
        end
        if (en[11]) begin
            s11_pl_reg <= pl_next;
            s11_l1_reg <= s10_l1_reg;
        end
        if (en[12]) begin
            s12_lv_reg <= lv_sum[19:0];
        end
        if (en[13]) begin
            noise_reg <= noise_next;
        end
    end

    // permutation table copies: one write and two registered reads each
    always_ff @(posedge aclk) begin
        if (wr_a) begin
            perm_a_mem[s5_idx_reg] <= s5_val_reg;
        end
        if (en[6]) begin
            s6_pj0_reg <= perm_a_mem[a0_addr];
            s6_pj1_reg <= perm_a_mem[a1_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_bc) begin
            perm_b_mem[s6_idx_reg] <= s6_val_reg;
        end
        if (en[7]) begin
            s7_g_reg[0] <= perm_b_mem[b0_addr][2:0];
            s7_g_reg[1] <= perm_b_mem[b1_addr][2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_bc) begin
            perm_c_mem[s6_idx_reg] <= s6_val_reg;
        end
        if (en[7]) begin
            s7_g_reg[2] <= perm_c_mem[c0_addr][2:0];
            s7_g_reg[3] <= perm_c_mem[c1_addr][2:0];
        end
    end

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // a ready receiver lets the whole pipeline move
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    // load items never turn into results
    a_load_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (en[NST] && vld_reg[NST-1] && !evl_reg[NST-1]) |=> !m_valid)
        else $error("load item produced a result");

    // a blocked table read stage keeps its item and its read data
    a_read_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[6] && !en[7]) |=> (vld_reg[6] && $stable(s6_pj0_reg)
                                    && $stable(s6_pj1_reg)))
        else $error("table read stage lost its item during a stall");

    // results stay within plus or minus one
    a_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_noise_value) <= 16'sd16384
                     && $signed(m_noise_value) >= -16'sd16384))
        else $error("noise value out of range");

endmodule

### tb/sv/gradient_noise_2d_tb.sv
// gradient_noise_2d_tb: self-checking bench for the 2d gradient noise block
// depends on gn2d_pkg and gradient_noise_2d; fills the permutation table first,
// then predicts every noise sample from a shadow table and cell size
module gradient_noise_2d_tb;
    import gn2d_pkg::*;

    localparam int LATTICE       = 256;
    localparam int SETTLE_CYCLES = 24;    // pipeline is 13 stages deep
    localparam int HOLD_CYCLES   = 120;
    localparam int WATCHDOG_MAX  = 3000;
    localparam longint GRAD_FULL = 16384;

    typedef struct {
        logic               req_type;
        logic [TAB_AW-1:0]  index;
        logic [BYTE_W-1:0]  value;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
    } sample_req_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [RECIP_W-1:0]         cfg_cell_recip = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_req_type = REQ_LOAD;
    logic [TAB_AW-1:0]          s_table_index = '0;
    logic [BYTE_W-1:0]          s_table_value = '0;
    logic [POS_W-1:0]           s_x_pos = '0;
    logic [POS_W-1:0]           s_y_pos = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [NOISE_W-1:0]  m_noise_value;

    sample_req_t                req_q[$];
    logic signed [NOISE_W-1:0]  noise_expect_q[$];
    logic [BYTE_W-1:0]          perm_shadow [TAB_DEPTH];
    logic [RECIP_W-1:0]         recip_shadow = CELL_RECIP_RESET;

    logic   in_xfer = 1'b0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    logic   hold_req = 1'b0;
    logic   hold_seen = 1'b0;
    int     hold_left = 0;
    int     fails = 0;
    int     loads_done = 0;
    int     samples_checked = 0;
    int     recips_used = 0;
    int     input_stalls = 0;
    int     quiet_cycles = 0;

    gradient_noise_2d #(
        .LATTICE_SIZE(LATTICE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_cell_recip(cfg_cell_recip),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_table_index(s_table_index),
        .s_table_value(s_table_value),
        .s_x_pos(s_x_pos),
        .s_y_pos(s_y_pos),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_noise_value(m_noise_value)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    // divide by 2^n, halves rounded toward plus infinity
    function automatic longint round_q(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [BYTE_W-1:0] perm_at(input int unsigned k);
        return perm_shadow[k % TAB_DEPTH];
    endfunction

    function automatic longint corner_dot(input logic [BYTE_W-1:0] hb,
                                          input longint dx, input longint dy);
        longint gx;
        longint gy;
        longint unit;
        unit = longint'(GRAD_UNIT);
        gx = 0;
        gy = 0;
        case (grad_sel_t'(hb[2:0]))
            GRAD_PP: begin gx = unit;       gy = unit;       end
            GRAD_NP: begin gx = -unit;      gy = unit;       end
            GRAD_PN: begin gx = unit;       gy = -unit;      end
            GRAD_NN: begin gx = -unit;      gy = -unit;      end
            GRAD_XP: begin gx = GRAD_FULL;  gy = 0;          end
            GRAD_XN: begin gx = -GRAD_FULL; gy = 0;          end
            GRAD_YP: begin gx = 0;          gy = GRAD_FULL;  end
            GRAD_YN: begin gx = 0;          gy = -GRAD_FULL; end
        endcase
        return round_q(gx * dx + gy * dy, 14);
    endfunction

    // 3t^2 - 2t^3 with t in Q0.16, exact then rounded to Q1.16
    function automatic longint fade_q16(input longint unsigned f);
        longint unsigned sq;
        longint unsigned cu;
        longint unsigned c48;
        sq = f * f;
        cu = sq * f;
        c48 = 3 * (sq << 16) - 2 * cu;
        return longint'((c48 + (64'd1 << 31)) >> 32);
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint c);
        return a + round_q(c * (b - a), 16);
    endfunction

    function automatic logic signed [NOISE_W-1:0] noise_at(input logic [POS_W-1:0] xp,
                                                          input logic [POS_W-1:0] yp);
        longint unsigned px;
        longint unsigned py;
        int unsigned ci;
        int unsigned cj;
        logic [BYTE_W-1:0] pj0;
        logic [BYTE_W-1:0] pj1;
        longint fx, fy, s, t, u, v, cx, cy, l1, l2, r;
        px = xp;
        py = yp;
        px = px * recip_shadow;
        py = py * recip_shadow;
        ci = (px >> 24) % LATTICE;
        cj = (py >> 24) % LATTICE;
        fx = longint'((px >> 8) & 64'hFFFF);
        fy = longint'((py >> 8) & 64'hFFFF);
        pj0 = perm_at(cj);
        pj1 = perm_at(cj + 1);
        s = corner_dot(perm_at(ci + pj0), fx, fy);
        t = corner_dot(perm_at(ci + 1 + pj0), fx - 65536, fy);
        u = corner_dot(perm_at(ci + pj1), fx, fy - 65536);
        v = corner_dot(perm_at(ci + 1 + pj1), fx - 65536, fy - 65536);
        cx = fade_q16(fx);
        cy = fade_q16(fy);
        l1 = blend(s, t, cx);
        l2 = blend(u, v, cx);
        r = round_q(blend(l1, l2, cy), 2);
        if (r > longint'(NOISE_MAX))
            r = longint'(NOISE_MAX);
        if (r < longint'(NOISE_MIN))
            r = longint'(NOISE_MIN);
        return r[NOISE_W-1:0];
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [POS_W-1:0] rand_pos();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return POS_W'($urandom);
        else if (pick < 80)
            return POS_W'($urandom_range(4095));
        else
            return {POS_W{1'b1}} - POS_W'($urandom_range(511));
    endfunction

    task automatic push_load(input logic [TAB_AW-1:0] idx, input logic [BYTE_W-1:0] val);
        sample_req_t r;
        r.req_type = REQ_LOAD;
        r.index = idx;
        r.value = val;
        r.x = rand_pos();
        r.y = rand_pos();
        req_q.push_back(r);
    endtask

    task automatic push_eval(input logic [POS_W-1:0] xp, input logic [POS_W-1:0] yp);
        sample_req_t r;
        r.req_type = REQ_EVAL;
        r.index = TAB_AW'($urandom);
        r.value = BYTE_W'($urandom);
        r.x = xp;
        r.y = yp;
        req_q.push_back(r);
    endtask

    // mostly samples with a table rewrite now and then
    task automatic push_random(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 15)
                push_load(TAB_AW'($urandom), BYTE_W'($urandom));
            else
                push_eval(rand_pos(), rand_pos());
        end
    endtask

    // wait until the pipeline is empty so the cell size may change
    task automatic settle();
        while (req_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (noise_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_recip(input logic [RECIP_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_cell_recip <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        recips_used++;
    endtask

    initial begin : stimulus
        int k;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // cell size one: fill the whole table, then edges and wrap points
        write_recip(17'd65536);
        for (k = 0; k < TAB_DEPTH; k++)
            push_load(k[TAB_AW-1:0], BYTE_W'($urandom));
        push_load(9'd0, 8'h00);
        push_load(9'd511, 8'hFF);
        push_load(9'd256, 8'hA5);
        push_load(9'd255, 8'h5A);
        push_eval(20'h00000, 20'h00000);
        push_eval(20'hFFFFF, 20'hFFFFF);
        push_eval(20'hFFFFF, 20'h00000);
        push_eval(20'h00000, 20'hFFFFF);
        push_eval(20'h00080, 20'h00080);
        push_eval(20'h000FF, 20'h000FF);
        push_eval(20'h00001, 20'h000FF);
        push_eval(20'h00100, 20'h00100);
        push_eval(20'h0FF80, 20'h0FF40);
        push_eval(20'h10000, 20'h10000);
        push_eval(20'h100C0, 20'hFFF40);
        push_eval(20'hAAAAA, 20'h55555);
        push_eval(20'h55555, 20'hAAAAA);
        push_eval(20'h00040, 20'h000C0);
        push_eval(20'h7FFFF, 20'h80000);
        push_eval(20'h80000, 20'h7FFFF);
        push_eval(20'h01234, 20'h0FEDC);
        push_eval(20'h0FF00, 20'h00000);
        settle();

        // reset cell size, receiver holds off long enough to back up the input
        write_recip(CELL_RECIP_RESET);
        hold_req = 1'b1;
        push_random(100);
        settle();

        send_idle_pct = 77;
        write_recip(17'd1);
        push_random(60);
        settle();

        send_idle_pct = 0;
        stall_pct = 77;
        write_recip(RECIP_W'($urandom_range(65536, 1)));
        push_random(80);
        settle();

        // zero and the top of the register are used as given
        send_idle_pct = 9;
        stall_pct = 9;
        write_recip(17'd0);
        push_random(50);
        settle();

        write_recip(17'h1FFFF);
        push_random(50);
        settle();

        send_idle_pct = 0;
        stall_pct = 0;
        write_recip(RECIP_W'($urandom));
        push_random(60);
        settle();

        $display("covered %0d table loads and %0d noise samples over %0d cell sizes",
                 loads_done, samples_checked, recips_used);
        $display("input held back by the block for %0d cycles", input_stalls);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fails);
            $display("TEST FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------- driver

    always @(negedge aclk) begin : drive_proc
        sample_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_xfer) begin
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = req_q.pop_front();
                s_valid <= 1'b1;
                s_req_type <= nxt.req_type;
                s_table_index <= nxt.index;
                s_table_value <= nxt.value;
                s_x_pos <= nxt.x;
                s_y_pos <= nxt.y;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin : watch_proc
        logic signed [NOISE_W-1:0] want;
        in_xfer <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                recip_shadow = cfg_cell_recip;
            if (s_valid && !s_ready)
                input_stalls++;
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_LOAD) begin
                    perm_shadow[s_table_index] = s_table_value;
                    loads_done++;
                end else begin
                    noise_expect_q.push_back(noise_at(s_x_pos, s_y_pos));
                end
            end
            if (m_valid && m_ready) begin
                if (noise_expect_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, noise_value %0d",
                             $time, m_noise_value);
                    fails++;
                end else begin
                    want = noise_expect_q.pop_front();
                    samples_checked++;
                    if (m_noise_value !== want) begin
                        $display("%0t: noise_value expected %0d actual %0d",
                                 $time, want, m_noise_value);
                        fails++;
                    end
                end
            end
        end
    end

    // no transfer of any kind for too long means the block hung
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, noise_expect_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
